### sv/sprite_frame_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Sprite frame sequencer assertion macros
// Short forms for the concurrent checks used in the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define SFS_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define SFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define SFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Field widths, reset values, codes and controller states shared by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

   // Default sizing
   localparam int SFS_MAX_FRAMES   = 16;
   localparam int SFS_MAX_ADVANCES = 16;

   // Field widths
   localparam int OPCODE_W   = 2;
   localparam int DT_W       = 16;
   localparam int ENTRY_W    = 4;
   localparam int LEN_W      = 16;
   localparam int FRAME_OUT_W = 4;
   localparam int RATE_W     = 8;
   localparam int COUNT_REG_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int ACC_W      = 32;
   localparam int ADD_W      = DT_W + RATE_W;

   // Register reset values
   localparam logic [RATE_W-1:0]      RATE_RESET  = RATE_W'(30);
   localparam logic [COUNT_REG_W-1:0] COUNT_RESET = '0;
   localparam logic                   LOOP_RESET  = 1'b1;
   localparam logic                   BACK_RESET  = 1'b0;

   // Request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK    = 2'd0,
      OP_LOAD    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_RATE    = 2'd0,
      CSR_FRAME_COUNT   = 2'd1,
      CSR_LOOP_ENABLE   = 2'd2,
      CSR_PLAY_BACKWARD = 2'd3
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_STEP,
      ST_FINAL
   } state_type;

endpackage

`default_nettype wire

### sv/sfs_frame_table.sv
// ----------------------------------------------------------------------------
// Frame length table
// Single-port-write, single-port-read synchronous memory of Q8.8 frame
// lengths with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_frame_table #(
   parameter int DEPTH = sfs_pkg::SFS_MAX_FRAMES
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [sfs_pkg::LEN_W-1:0]    wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output      logic [sfs_pkg::LEN_W-1:0]    rd_data
);
   import sfs_pkg::*;

   logic [LEN_W-1:0] mem [DEPTH];
   logic [LEN_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps an animation through a table of per-frame lengths as time is ticked.
// ----------------------------------------------------------------------------
// One request is processed at a time. A load, restart or no-op request passes
// from the acceptance cycle to the closing state, which presents its single
// result; so does a tick on a finished animation or with one frame or fewer.
// Any other tick makes 0 to MAX_ADVANCES frame steps: the acceptance cycle
// registers delta_time * frame_rate, the accumulate state adds it to the
// accumulator and reads the current length, the compare/subtract loop decides
// the steps in turn (the next length is read from the table while the current
// step is decided), a closing compare finds no further step, and the closing
// state presents the final result. When the loop ends on the step cap or on
// reaching the end without looping, the closing compare is skipped. Stalls on
// the result side hold the loop and the closing state. Each frame step
// produces one result; the last result of every request carries
// rsp_last_result. The length table is not cleared; a tick must not visit an
// entry never loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer #(
   parameter int MAX_FRAMES   = sfs_pkg::SFS_MAX_FRAMES,
   parameter int MAX_ADVANCES = sfs_pkg::SFS_MAX_ADVANCES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [sfs_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [sfs_pkg::DT_W-1:0]          req_delta_time,
   input  wire logic [sfs_pkg::ENTRY_W-1:0]       req_entry_index,
   input  wire logic [sfs_pkg::LEN_W-1:0]         req_entry_length,
   // result channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [sfs_pkg::FRAME_OUT_W-1:0]   rsp_frame_index,
   output      logic                              rsp_frame_changed,
   output      logic                              rsp_anim_finished,
   output      logic                              rsp_last_result,
   // configuration port
   input  wire logic                              csr_write_enable,
   input  wire logic [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfs_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import sfs_pkg::*;

`include "sprite_frame_sequencer_defines.svh"

   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int COUNT_W = $clog2(MAX_FRAMES + 1);
   localparam int CNT_W   = $clog2(MAX_ADVANCES + 1);
   localparam logic [CNT_W-1:0] ADV_LAST = CNT_W'(MAX_ADVANCES - 1);
   localparam logic [CNT_W-1:0] ADV_MAX  = CNT_W'(MAX_ADVANCES);

   // Configuration registers
   logic [RATE_W-1:0]      frame_rate_ff;
   logic [COUNT_REG_W-1:0] frame_count_ff;
   logic                   loop_enable_ff;
   logic                   play_backward_ff;

   // Sequencer state
   state_type              state_ff, state_in;
   logic [FRAME_W-1:0]     cur_ff, cur_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   fin_ff, fin_in;
   logic                   pending_ff, pending_in;
   logic [CNT_W-1:0]       step_cnt_ff, step_cnt_in;
   logic [ADD_W-1:0]       add_ff, add_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic                   rsp_fin_ff, rsp_fin_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Table interface
   logic                   tbl_wr_en;
   logic [FRAME_W-1:0]     tbl_wr_addr;
   logic                   tbl_rd_en;
   logic [FRAME_W-1:0]     tbl_rd_addr;
   logic [LEN_W-1:0]       tbl_rd_data;

   // Derived values
   logic [COUNT_W-1:0]     used_count;
   logic [FRAME_W-1:0]     last_frame;
   logic [FRAME_W-1:0]     start_frame;
   logic [FRAME_W-1:0]     step_frame;
   logic                   step_finish;
   logic [ACC_W-1:0]       thr;
   logic [ACC_W:0]         acc_sum;
   logic                   req_accept;
   logic                   out_free;
   logic                   emit;
   logic                   emit_changed;
   logic                   emit_last;

   // Frames in use, saturated to the table depth
   assign used_count = (32'(frame_count_ff) > 32'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                               : COUNT_W'(frame_count_ff);
   assign last_frame  = FRAME_W'(used_count - COUNT_W'(1));
   assign start_frame = (play_backward_ff && (used_count != '0)) ? last_frame : '0;

   // One frame step from the current frame, with wrap or stop at the end
   always_comb begin
      step_frame  = cur_ff;
      step_finish = 1'b0;
      if (play_backward_ff) begin
         if (cur_ff == '0) begin
            if (loop_enable_ff) begin
               step_frame = last_frame;
            end else begin
               step_finish = 1'b1;
            end
         end else begin
            step_frame = cur_ff - FRAME_W'(1);
         end
      end else begin
         if (cur_ff == last_frame) begin
            if (loop_enable_ff) begin
               step_frame = '0;
            end else begin
               step_finish = 1'b1;
            end
         end else begin
            step_frame = cur_ff + FRAME_W'(1);
         end
      end
   end

   // Threshold is the Q8.8 length scaled to 1/65536 frame units
   assign thr     = ACC_W'({tbl_rd_data, 8'h00});
   assign acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(add_ff);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      pending_in   = pending_ff;
      step_cnt_in  = step_cnt_ff;
      add_in       = add_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = FRAME_W'(req_entry_index);
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = cur_ff;
      emit         = 1'b0;
      emit_changed = 1'b0;
      emit_last    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pending_in = 1'b0;
               state_in   = ST_FINAL;
               case (opcode_type'(req_opcode))
                  OP_TICK: begin
                     if (fin_ff) begin
                        state_in = ST_FINAL;
                     end else if (used_count <= COUNT_W'(1)) begin
                        cur_in = '0;
                     end else begin
                        if (COUNT_W'(cur_ff) >= used_count) begin
                           cur_in = '0;
                        end
                        add_in   = ADD_W'(req_delta_time) * ADD_W'(frame_rate_ff);
                        state_in = ST_ACCUM;
                     end
                  end
                  OP_LOAD: begin
                     tbl_wr_en = (32'(req_entry_index) < 32'(MAX_FRAMES));
                  end
                  OP_RESTART: begin
                     acc_in     = '0;
                     fin_in     = 1'b0;
                     cur_in     = start_frame;
                     pending_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_FINAL;
                  end
               endcase
            end
         end

         // Saturating accumulate, fetch the current frame's length
         ST_ACCUM: begin
            acc_in      = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = cur_ff;
            step_cnt_in = '0;
            pending_in  = 1'b0;
            state_in    = ST_STEP;
         end

         // Compare and step; the previous step's result goes out once known
         // not to be the last one
         ST_STEP: begin
            tbl_rd_en   = !pending_ff || out_free;
            tbl_rd_addr = step_frame;
            if (acc_ff <= thr) begin
               state_in = ST_FINAL;
            end else if (!pending_ff || out_free) begin
               emit         = pending_ff;
               emit_changed = 1'b1;
               acc_in       = acc_ff - thr;
               cur_in       = step_frame;
               fin_in       = fin_ff || step_finish;
               pending_in   = 1'b1;
               step_cnt_in  = step_cnt_ff + CNT_W'(1);
               if (step_finish || (step_cnt_ff == ADV_LAST)) begin
                  state_in = ST_FINAL;
               end
            end
         end

         // Closing result of the request
         ST_FINAL: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_changed = pending_ff;
               emit_last    = 1'b1;
               pending_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: loads from current state, clears when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_frame_in   = rsp_frame_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_fin_in     = rsp_fin_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_frame_in   = FRAME_OUT_W'(cur_ff);
         rsp_changed_in = emit_changed;
         rsp_fin_in     = fin_ff;
         rsp_last_in    = emit_last;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         acc_ff       <= '0;
         fin_ff       <= 1'b0;
         pending_ff   <= 1'b0;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         acc_ff       <= acc_in;
         fin_ff       <= fin_in;
         pending_ff   <= pending_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      add_ff         <= add_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rate_ff    <= RATE_RESET;
         frame_count_ff   <= COUNT_RESET;
         loop_enable_ff   <= LOOP_RESET;
         play_backward_ff <= BACK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_RATE:    frame_rate_ff    <= csr_write_data[RATE_W-1:0];
            CSR_FRAME_COUNT:   frame_count_ff   <= csr_write_data[COUNT_REG_W-1:0];
            CSR_LOOP_ENABLE:   loop_enable_ff   <= csr_write_data[0];
            CSR_PLAY_BACKWARD: play_backward_ff <= csr_write_data[0];
            default: begin
               frame_rate_ff <= frame_rate_ff;
            end
         endcase
      end
   end

   // Frame length table
   sfs_frame_table #(
      .DEPTH (MAX_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_entry_length),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_frame_changed = rsp_changed_ff;
   assign rsp_anim_finished = rsp_fin_ff;
   assign rsp_last_result   = rsp_last_ff;

   // Checks
   `SFS_ASSERT_IMPLIES(a_frame_in_range, clock, reset, state_ff == ST_STEP, COUNT_W'(cur_ff) < used_count, "frame outside table while stepping")
   `SFS_ASSERT_HOLDS(a_step_cap, clock, reset, step_cnt_ff <= ADV_MAX, "step count beyond cap")
   `SFS_ASSERT_HOLDS(a_no_rw_overlap, clock, reset, !(tbl_wr_en && tbl_rd_en), "table write and read collide")
   `SFS_ASSERT_NEXT(a_hold_on_stall, clock, reset, (state_ff == ST_STEP) && pending_ff && !out_free, $stable(acc_ff) && $stable(cur_ff), "state moved while result blocked")

endmodule

`default_nettype wire

### test/tb_sprite_frame_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives tick, load, restart and no-op requests through the valid/stall
// request channel and checks every frame report against a behavioural
// predictor kept in step with the register settings. Directed cases cover
// reset defaults, non-looped finishing, backward play and the step cap;
// random phases vary the registers, and in all but the first both sides
// idle and stall at random.
// ----------------------------------------------------------------------------

module tb_sprite_frame_sequencer;
   import sfs_pkg::*;

   localparam int MAX_FRAMES    = SFS_MAX_FRAMES;
   localparam int MAX_ADVANCES  = SFS_MAX_ADVANCES;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 3 * (MAX_ADVANCES + 4);
   localparam int IDLE_PERCENT  = 23;

   // One frame report as seen on the result channel
   typedef struct packed {
      logic [FRAME_OUT_W-1:0] frame;
      logic                   changed;
      logic                   finished;
      logic                   is_last;
   } frame_report_type;

   // DUT signals
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   opcode_type             req_opcode = OP_NOP;
   logic [DT_W-1:0]        req_delta_time = '0;
   logic [ENTRY_W-1:0]     req_entry_index = '0;
   logic [LEN_W-1:0]       req_entry_length = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FRAME_OUT_W-1:0] rsp_frame_index;
   logic                   rsp_frame_changed;
   logic                   rsp_anim_finished;
   logic                   rsp_last_result;
   logic                   csr_write_enable = 1'b0;
   csr_index_type          csr_index = CSR_FRAME_RATE;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Predictor state: registers, animation state and the length table
   logic [RATE_W-1:0]      cfg_rate  = RATE_RESET;
   logic [COUNT_REG_W-1:0] cfg_count = COUNT_RESET;
   logic                   cfg_loop  = LOOP_RESET;
   logic                   cfg_back  = BACK_RESET;
   int unsigned            anim_frame = 0;
   logic [ACC_W-1:0]       anim_time  = '0;
   logic                   anim_done  = 1'b0;
   logic [LEN_W-1:0]       length_table [MAX_FRAMES];

   frame_report_type       pending_frames [$];

   // Run control and bookkeeping
   bit                     req_gaps_on = 1'b0;
   bit                     rsp_gaps_on = 1'b0;
   int                     hold_length = 0;
   int                     hold_left = 0;
   int                     mismatches = 0;
   int                     cycle_count = 0;
   int                     reports_checked = 0;
   int                     ticks_sent = 0;
   int                     loads_sent = 0;
   int                     restarts_sent = 0;
   int                     nops_sent = 0;

   sprite_frame_sequencer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_delta_time    (req_delta_time),
      .req_entry_index   (req_entry_index),
      .req_entry_length  (req_entry_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_frame_changed (rsp_frame_changed),
      .rsp_anim_finished (rsp_anim_finished),
      .rsp_last_result   (rsp_last_result),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, pending_frames.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: long hold-offs on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_length != 0) begin
         hold_left = hold_length;
         hold_length = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Queue one report carrying the present frame and finished flag
   function automatic void add_report(input logic changed);
      frame_report_type r;
      r.frame    = FRAME_OUT_W'(anim_frame);
      r.changed  = changed;
      r.finished = anim_done;
      r.is_last  = 1'b0;
      pending_frames.push_back(r);
   endfunction

   // Advance the animation by one tick, at most MAX_ADVANCES frame steps
   function automatic void advance_animation(input logic [DT_W-1:0] dt);
      int unsigned      frames;
      logic [ACC_W:0]   sum;
      logic [ACC_W-1:0] step_len;
      int               moves;
      bit               halt;
      frames = (cfg_count > MAX_FRAMES) ? MAX_FRAMES : cfg_count;
      moves = 0;
      halt = 1'b0;
      if (!anim_done) begin
         if (frames <= 1) begin
            anim_frame = 0;
         end else begin
            if (anim_frame >= frames)
               anim_frame = 0;
            sum = {1'b0, anim_time} + (33'(dt) * 33'(cfg_rate));
            anim_time = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            while (moves < MAX_ADVANCES && !halt) begin
               step_len = 32'(length_table[anim_frame]) << 8;
               if (anim_time <= step_len) begin
                  halt = 1'b1;
               end else begin
                  anim_time -= step_len;
                  if (cfg_back) begin
                     if (anim_frame == 0) begin
                        if (cfg_loop) begin
                           anim_frame = frames - 1;
                        end else begin
                           anim_done = 1'b1;
                           halt = 1'b1;
                        end
                     end else begin
                        anim_frame--;
                     end
                  end else begin
                     if (anim_frame + 1 >= frames) begin
                        if (cfg_loop) begin
                           anim_frame = 0;
                        end else begin
                           anim_frame = frames - 1;
                           anim_done = 1'b1;
                           halt = 1'b1;
                        end
                     end else begin
                        anim_frame++;
                     end
                  end
                  add_report(1'b1);
                  moves++;
               end
            end
         end
      end
      if (moves == 0)
         add_report(1'b0);
   endfunction

   // Work out the reports of one accepted request and mark the final one
   function automatic void predict_request(input opcode_type op, input logic [DT_W-1:0] dt,
                                           input logic [ENTRY_W-1:0] idx,
                                           input logic [LEN_W-1:0] len);
      frame_report_type r;
      int unsigned      frames;
      frames = (cfg_count > MAX_FRAMES) ? MAX_FRAMES : cfg_count;
      case (op)
         OP_TICK: begin
            advance_animation(dt);
         end
         OP_LOAD: begin
            length_table[idx] = len;
            add_report(1'b0);
         end
         OP_RESTART: begin
            anim_time = '0;
            anim_done = 1'b0;
            anim_frame = (cfg_back && frames > 0) ? frames - 1 : 0;
            add_report(1'b1);
         end
         default: begin
            add_report(1'b0);
         end
      endcase
      r = pending_frames.pop_back();
      r.is_last = 1'b1;
      pending_frames.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   function automatic void compare_field(input string field, input logic [3:0] want,
                                         input logic [3:0] got);
      if (got !== want) begin
         if (mismatches < 50)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_reports
      frame_report_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            if (mismatches < 50)
               $display("%0t: unexpected report, expected none, actual frame %0d",
                        $time, rsp_frame_index);
            mismatches++;
         end else begin
            want = pending_frames.pop_front();
            compare_field("frame_index", want.frame, rsp_frame_index);
            compare_field("frame_changed", want.changed, rsp_frame_changed);
            compare_field("anim_finished", want.finished, rsp_anim_finished);
            compare_field("last_result", want.is_last, rsp_last_result);
            reports_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------------

   // Offer one request; valid stays high on return so back-to-back requests
   // need no second assignment in the same step
   task automatic send_request(input opcode_type op, input logic [DT_W-1:0] dt,
                               input logic [ENTRY_W-1:0] idx, input logic [LEN_W-1:0] len);
      while (req_gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_delta_time   <= dt;
      req_entry_index  <= idx;
      req_entry_length <= len;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_request(op, dt, idx, len);
      case (op)
         OP_TICK:    ticks_sent++;
         OP_LOAD:    loads_sent++;
         OP_RESTART: restarts_sent++;
         default:    nops_sent++;
      endcase
   endtask

   // Random request: mostly ticks, payload fields random whatever the opcode
   task automatic send_random_request();
      int               pick;
      opcode_type       op;
      logic [DT_W-1:0]  dt;
      logic [LEN_W-1:0] len;
      pick = $urandom_range(0, 99);
      op = (pick < 62) ? OP_TICK : (pick < 77) ? OP_LOAD : (pick < 92) ? OP_RESTART : OP_NOP;
      dt = $urandom_range(0, 1) ? DT_W'($urandom_range(0, 4095)) : DT_W'($urandom);
      len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 1024));
      send_request(op, dt, ENTRY_W'($urandom), len);
   endtask

   // Stop offering and wait for every outstanding report
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Write all four registers; only called with the block idle
   task automatic configure(input logic [RATE_W-1:0] rate, input logic [COUNT_REG_W-1:0] count,
                            input logic loop_on, input logic backward);
      write_register(CSR_FRAME_RATE, CSR_DATA_W'(rate));
      write_register(CSR_FRAME_COUNT, CSR_DATA_W'(count));
      write_register(CSR_LOOP_ENABLE, CSR_DATA_W'(loop_on));
      write_register(CSR_PLAY_BACKWARD, CSR_DATA_W'(backward));
      csr_write_enable <= 1'b0;
      cfg_rate  = rate;
      cfg_count = count;
      cfg_loop  = loop_on;
      cfg_back  = backward;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings: no frames, so ticks hold frame 0
   task automatic test_reset_defaults();
      send_request(OP_TICK, 16'hFFFF, 4'h0, 16'h0000);
      send_request(OP_NOP, 16'h0000, 4'hF, 16'hFFFF);
      send_request(OP_RESTART, 16'h1234, 4'h5, 16'h5555);
      drain_reports();
   endtask

   // Fill the whole table so no tick ever reads an unloaded entry
   task automatic test_table_load();
      logic [LEN_W-1:0] lengths [MAX_FRAMES];
      lengths = '{16'h0000, 16'h0100, 16'h5555, 16'hFFFF, 16'hAAAA, 16'h0001, 16'h0040,
                  16'h0200, 16'h1000, 16'h0000, 16'h0080, 16'h0300, 16'h7FFF, 16'h8000,
                  16'h0010, 16'h0400};
      for (int i = 0; i < MAX_FRAMES; i++)
         send_request(OP_LOAD, DT_W'($urandom), ENTRY_W'(i), lengths[i]);
      drain_reports();
   endtask

   // Non-looped finish, backward play, out-of-range frame, saturated count,
   // zero rate, a single frame and a backward restart with no frames
   task automatic test_play_modes();
      configure(8'd255, 5'd4, 1'b0, 1'b0);
      send_request(OP_RESTART, 16'h0000, 4'h0, 16'h0000);
      repeat (3) send_request(OP_TICK, 16'hFFFF, 4'h0, 16'h0000);
      drain_reports();

      configure(8'd255, 5'd4, 1'b1, 1'b1);
      send_request(OP_RESTART, 16'h0000, 4'h0, 16'h0000);
      send_request(OP_TICK, 16'hFFFF, 4'h0, 16'h0000);
      drain_reports();

      // restart on frame 15, then shrink the animation under it
      configure(8'd255, 5'd16, 1'b1, 1'b1);
      send_request(OP_RESTART, 16'h0000, 4'h0, 16'h0000);
      drain_reports();
      configure(8'd255, 5'd2, 1'b1, 1'b1);
      send_request(OP_TICK, 16'h0010, 4'h0, 16'h0000);
      drain_reports();

      configure(8'd0, 5'd31, 1'b1, 1'b0);
      send_request(OP_TICK, 16'hFFFF, 4'h0, 16'h0000);
      drain_reports();

      configure(8'd30, 5'd1, 1'b1, 1'b0);
      send_request(OP_TICK, 16'h0000, 4'h0, 16'h0000);
      drain_reports();

      configure(8'd30, 5'd0, 1'b1, 1'b1);
      send_request(OP_RESTART, 16'h0000, 4'h0, 16'h0000);
      drain_reports();
   endtask

   // Zero-length frames step without using up time, so every tick runs
   // into the step cap
   task automatic test_step_cap();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      configure(8'd255, 5'd2, 1'b1, 1'b0);
      send_request(OP_LOAD, 16'h0000, 4'h0, 16'h0000);
      send_request(OP_LOAD, 16'h0000, 4'h1, 16'h0000);
      send_request(OP_RESTART, 16'h0000, 4'h0, 16'h0000);
      repeat (20) send_request(OP_TICK, 16'hFFFF, 4'h0, 16'h0000);
      drain_reports();
   endtask

   // Receiver holds off while requests keep coming, then the sender pauses
   task automatic test_output_backpressure();
      req_gaps_on = 1'b0;
      configure(8'd200, 5'd6, 1'b1, 1'b0);
      for (int i = 0; i < 6; i++)
         send_request(OP_LOAD, 16'h0000, ENTRY_W'(i), LEN_W'($urandom_range(1, 2048)));
      send_request(OP_RESTART, 16'h0000, 4'h0, 16'h0000);
      hold_length = 300;
      repeat (24) send_request(OP_TICK, DT_W'($urandom), ENTRY_W'($urandom), LEN_W'($urandom));
      drain_reports();
   endtask

   // Random phases, each with its own register settings
   task automatic test_random_phases();
      int                     pick;
      logic [RATE_W-1:0]      rate;
      logic [COUNT_REG_W-1:0] count;
      for (int phase = 0; phase < 8; phase++) begin
         // first phase runs without any idling on either side
         req_gaps_on = (phase != 0);
         rsp_gaps_on = (phase != 0);
         pick = $urandom_range(0, 19);
         rate = (pick == 0) ? 8'd0 : (pick < 3) ? 8'd1 : (pick < 5) ? 8'd255
                : RATE_W'($urandom_range(1, 255));
         if (phase == 1)
            rate = 8'd1;
         pick = $urandom_range(0, 9);
         count = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd1 : (pick == 2) ? 5'd16
                 : (pick == 3) ? COUNT_REG_W'($urandom_range(17, 31))
                 : COUNT_REG_W'($urandom_range(2, 16));
         configure(rate, count, 1'($urandom), 1'($urandom));
         if ($urandom_range(0, 9) < 7)
            send_request(OP_RESTART, DT_W'($urandom), ENTRY_W'($urandom), LEN_W'($urandom));
         repeat (28) send_random_request();
         drain_reports();
      end
      rsp_gaps_on = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_table_load();
      test_play_modes();
      test_step_cap();
      test_output_backpressure();
      test_random_phases();

      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d ticks, %0d loads, %0d restarts and %0d no-ops in %0d cycles;",
               ticks_sent, loads_sent, restarts_sent, nops_sent, cycle_count);
      $display("checked %0d frame reports, %0d mismatching fields.",
               reports_checked, mismatches);
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
